// ===== hdl/gyro_quaternion_integrator_defines.svh =====
// Assertion macros for the gyro quaternion integrator checker.
// Depends on nothing; included by the checker file.
`ifndef GYRO_QUATERNION_INTEGRATOR_DEFINES_SVH
`define GYRO_QUATERNION_INTEGRATOR_DEFINES_SVH

// Implication checked in the next cycle, off while reset is high.
`define GQI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gqi assertion failed");

// Same-cycle implication, off while reset is high.
`define GQI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gqi assertion failed");

// Implication checked in the next cycle, active through reset.
`define GQI_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gqi assertion failed");

`endif

// ===== hdl/gqi_pkg.sv =====
// Types, constants and small tables of the gyro quaternion integrator.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package gqi_pkg;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_QPROD, OP_MBUILD, OP_GMUL, OP_SQ, OP_SQRT, OP_CHECK,
    OP_AMUL, OP_AMOD, OP_FOLD, OP_CORDIC, OP_CS, OP_AXMUL, OP_AXDIV, OP_AXDONE,
    OP_QMUL, OP_FINISH
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_QPROD, S_MBUILD, S_GMUL, S_SQ, S_SQRT, S_CHECK, S_AMUL, S_AMOD,
    S_FOLD, S_CORDIC, S_CS, S_AXMUL, S_AXDIV, S_AXDONE, S_QMUL, S_FINISH
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] idx;
    logic       ph;
    logic [1:0] ax;
  } cmd_t;

  typedef struct packed {
    logic slow;
  } status_t;

  localparam logic [2:0] REG_INIT_W   = 3'd0;
  localparam logic [2:0] REG_INIT_X   = 3'd1;
  localparam logic [2:0] REG_INIT_Y   = 3'd2;
  localparam logic [2:0] REG_INIT_Z   = 3'd3;
  localparam logic [2:0] REG_MIN_RATE = 3'd4;

  localparam logic [4:0] QPROD_LAST = 5'd9;
  localparam logic [4:0] GMUL_LAST  = 5'd8;
  localparam logic [4:0] SQ_LAST    = 5'd2;
  localparam logic [4:0] SQRT_LAST  = 5'd31;
  localparam logic [4:0] AMOD_LAST  = 5'd4;
  localparam logic [4:0] DIV_LAST   = 5'd31;
  localparam logic [4:0] QMUL_LAST  = 5'd15;
  localparam logic [1:0] AX_LAST    = 2'd2;

  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic [23:0]        MIN_RATE_RST = 24'd17;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic [37:0]        TWO_PI_U38  = 38'd6746518852;
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
  localparam logic signed [65:0] ROUND_Q30   = 66'sd536870912;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  atan_q30 = 32'd843314856;
      5'd1:  atan_q30 = 32'd497837829;
      5'd2:  atan_q30 = 32'd263043836;
      5'd3:  atan_q30 = 32'd133525158;
      5'd4:  atan_q30 = 32'd67021686;
      5'd5:  atan_q30 = 32'd33543515;
      5'd6:  atan_q30 = 32'd16775850;
      5'd7:  atan_q30 = 32'd8388437;
      5'd8:  atan_q30 = 32'd4194282;
      5'd9:  atan_q30 = 32'd2097149;
      5'd10: atan_q30 = 32'd1048575;
      5'd31: atan_q30 = 32'd0;
      default: atan_q30 = 32'd1 << (5'd30 - i);
    endcase
  endfunction

  // Factor pairs of the ten quaternion products: ww xx yy zz xy xz yz wx wy wz.
  function automatic logic [1:0] qprod_a(input logic [3:0] i);
    case (i)
      4'd0: qprod_a = 2'd0;
      4'd1: qprod_a = 2'd1;
      4'd2: qprod_a = 2'd2;
      4'd3: qprod_a = 2'd3;
      4'd4: qprod_a = 2'd1;
      4'd5: qprod_a = 2'd1;
      4'd6: qprod_a = 2'd2;
      default: qprod_a = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] qprod_b(input logic [3:0] i);
    case (i)
      4'd0: qprod_b = 2'd0;
      4'd1: qprod_b = 2'd1;
      4'd2: qprod_b = 2'd2;
      4'd3: qprod_b = 2'd3;
      4'd4: qprod_b = 2'd2;
      4'd5: qprod_b = 2'd3;
      4'd6: qprod_b = 2'd3;
      4'd7: qprod_b = 2'd1;
      4'd8: qprod_b = 2'd2;
      default: qprod_b = 2'd3;
    endcase
  endfunction

  function automatic logic [1:0] mat_row(input logic [3:0] i);
    case (i)
      4'd0, 4'd1, 4'd2: mat_row = 2'd0;
      4'd3, 4'd4, 4'd5: mat_row = 2'd1;
      default:          mat_row = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] mat_col(input logic [3:0] i);
    case (i)
      4'd0, 4'd3, 4'd6: mat_col = 2'd0;
      4'd1, 4'd4, 4'd7: mat_col = 2'd1;
      default:          mat_col = 2'd2;
    endcase
  endfunction

  // Hamilton product W * q: term t of part k uses q[qmul_q] with sign qmul_neg.
  function automatic logic [1:0] qmul_q(input logic [3:0] i);
    case (i)
      4'd0: qmul_q = 2'd0;  4'd1: qmul_q = 2'd1;  4'd2: qmul_q = 2'd2;  4'd3: qmul_q = 2'd3;
      4'd4: qmul_q = 2'd1;  4'd5: qmul_q = 2'd0;  4'd6: qmul_q = 2'd3;  4'd7: qmul_q = 2'd2;
      4'd8: qmul_q = 2'd2;  4'd9: qmul_q = 2'd3;  4'd10: qmul_q = 2'd0; 4'd11: qmul_q = 2'd1;
      4'd12: qmul_q = 2'd3; 4'd13: qmul_q = 2'd2; 4'd14: qmul_q = 2'd1;
      default: qmul_q = 2'd0;
    endcase
  endfunction

  function automatic logic qmul_neg(input logic [3:0] i);
    case (i)
      4'd1, 4'd2, 4'd3, 4'd7, 4'd9, 4'd14: qmul_neg = 1'b1;
      default: qmul_neg = 1'b0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== hdl/gyro_quaternion_integrator.sv =====
// The result follows the 32-step square root when the rate is at or below min_rate,
// else the CORDIC and three 32-step axis divisions, all products on one shared
// multiplier. Items are taken one at a time, in idle only; the next is taken while
// a result waits; its own result stalls in the last step until that one is taken.
// Reset: synchronous, orientation and init registers to identity, min_rate 17.
`timescale 1ns / 1ps

module gyro_quaternion_integrator import gqi_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // rate_x, rate_y, rate_z, step_time
  input  logic         s_axis_tuser,  // restart
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic         m_axis_tuser   // held
);

  cmd_t    cmd;
  status_t status;
  logic signed [31:0] quat_w, quat_x, quat_y, quat_z;

  gqi_controller #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  gqi_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .restart   (s_axis_tuser),
    .rate_x    (s_axis_tdata[31:0]),
    .rate_y    (s_axis_tdata[63:32]),
    .rate_z    (s_axis_tdata[95:64]),
    .step_time (s_axis_tdata[119:96]),
    .cmd       (cmd),
    .status    (status),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .held      (m_axis_tuser)
  );

  assign m_axis_tdata = {quat_z, quat_y, quat_x, quat_w};

endmodule

// ===== hdl/gqi_controller.sv =====
// Sequencer of the gyro quaternion integrator: walks the datapath through
// its steps and runs both stream handshakes. Depends on gqi_pkg.
`timescale 1ns / 1ps

module gqi_controller import gqi_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);

  state_t     state, state_next;
  logic [4:0] idx, idx_next;
  logic       ph, ph_next;
  logic [1:0] ax, ax_next;
  logic       finish_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      ph        <= 1'b0;
      ax        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      ph    <= ph_next;
      ax    <= ax_next;
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    ph_next    = ph;
    ax_next    = ax;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_QPROD;
          idx_next   = '0;
          ph_next    = 1'b0;
        end
      end
      S_QPROD, S_GMUL, S_SQ, S_QMUL: begin
        if (!ph) begin
          ph_next = 1'b1;
        end else begin
          ph_next  = 1'b0;
          idx_next = idx + 5'd1;
          if (state == S_QPROD && idx == QPROD_LAST) begin
            state_next = S_MBUILD;
            idx_next   = '0;
          end else if (state == S_GMUL && idx == GMUL_LAST) begin
            state_next = S_SQ;
            idx_next   = '0;
          end else if (state == S_SQ && idx == SQ_LAST) begin
            state_next = S_SQRT;
            idx_next   = '0;
          end else if (state == S_QMUL && idx == QMUL_LAST) begin
            state_next = S_FINISH;
            idx_next   = '0;
          end
        end
      end
      S_MBUILD: state_next = S_GMUL;
      S_SQRT: begin
        idx_next = idx + 5'd1;
        if (idx == SQRT_LAST) begin
          state_next = S_CHECK;
          idx_next   = '0;
        end
      end
      S_CHECK: state_next = status.slow ? S_FINISH : S_AMUL;
      S_AMUL: begin
        if (!ph) begin
          ph_next = 1'b1;
        end else begin
          ph_next    = 1'b0;
          state_next = S_AMOD;
        end
      end
      S_AMOD: begin
        idx_next = idx + 5'd1;
        if (idx == AMOD_LAST) begin
          state_next = S_FOLD;
          idx_next   = '0;
        end
      end
      S_FOLD: state_next = S_CORDIC;
      S_CORDIC: begin
        idx_next = idx + 5'd1;
        if (idx == CORDIC_LAST) begin
          state_next = S_CS;
          idx_next   = '0;
        end
      end
      S_CS: begin
        state_next = S_AXMUL;
        ax_next    = '0;
      end
      S_AXMUL: begin
        if (!ph) begin
          ph_next = 1'b1;
        end else begin
          ph_next    = 1'b0;
          state_next = S_AXDIV;
          idx_next   = '0;
        end
      end
      S_AXDIV: begin
        idx_next = idx + 5'd1;
        if (idx == DIV_LAST) begin
          state_next = S_AXDONE;
          idx_next   = '0;
        end
      end
      S_AXDONE: begin
        if (ax == AX_LAST) begin
          state_next = S_QMUL;
        end else begin
          state_next = S_AXMUL;
          ax_next    = ax + 2'd1;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    finish_go = 1'b0;
    cmd.idx   = idx;
    cmd.ph    = ph;
    cmd.ax    = ax;
    cmd.op    = OP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      S_QPROD:  cmd.op = OP_QPROD;
      S_MBUILD: cmd.op = OP_MBUILD;
      S_GMUL:   cmd.op = OP_GMUL;
      S_SQ:     cmd.op = OP_SQ;
      S_SQRT:   cmd.op = OP_SQRT;
      S_CHECK:  cmd.op = OP_CHECK;
      S_AMUL:   cmd.op = OP_AMUL;
      S_AMOD:   cmd.op = OP_AMOD;
      S_FOLD:   cmd.op = OP_FOLD;
      S_CORDIC: cmd.op = OP_CORDIC;
      S_CS:     cmd.op = OP_CS;
      S_AXMUL:  cmd.op = OP_AXMUL;
      S_AXDIV:  cmd.op = OP_AXDIV;
      S_AXDONE: cmd.op = OP_AXDONE;
      S_QMUL:   cmd.op = OP_QMUL;
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          finish_go = 1'b1;
          cmd.op    = OP_FINISH;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== hdl/gqi_datapath.sv =====
// Datapath of the gyro quaternion integrator: one shared 33x33 multiplier,
// square root, angle reduction, CORDIC and divider steps. Depends on gqi_pkg.
`timescale 1ns / 1ps

module gqi_datapath import gqi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_data,
  input  logic               restart,
  input  logic signed [31:0] rate_x,
  input  logic signed [31:0] rate_y,
  input  logic signed [31:0] rate_z,
  input  logic [23:0]        step_time,
  input  cmd_t               cmd,
  output status_t            status,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic               held
);

  logic signed [31:0] q [4];
  logic signed [31:0] init_q [4];
  logic [23:0]        min_rate;
  logic signed [31:0] v [3];
  logic [23:0]        dt;
  logic signed [35:0] pr [10];
  logic signed [31:0] m [9];
  logic signed [39:0] acc;
  logic signed [31:0] g [3];
  logic [63:0]        sq, sr_x, sr_r;
  logic               held_r;
  logic [37:0]        am;
  logic signed [34:0] ang;
  logic signed [33:0] cx, cy;
  logic               flip;
  logic signed [31:0] sv;
  logic signed [31:0] wq [4];
  logic               neg;
  logic [32:0]        rem;
  logic [31:0]        nlo, quo;
  logic signed [31:0] nq [4];
  logic signed [31:0] oq [4];

  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [35:0] rnd;

  logic signed [39:0] gsum, qsum, qterm;
  logic [63:0]        xcur, rcur, sbit, trial;
  logic [37:0]        mod_d;
  logic signed [34:0] a1, at;
  logic signed [33:0] xs, ys;
  logic [63:0]        mag, num;
  logic [33:0]        diff;

  assign rnd = 36'((mp + ROUND_Q30) >>> 30);
  assign status.slow = (sr_r <= {40'd0, min_rate});

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_QPROD: begin
        ma = 33'(q[qprod_a(cmd.idx[3:0])]);
        mb = 33'(q[qprod_b(cmd.idx[3:0])]);
      end
      OP_GMUL: begin
        ma = 33'(m[cmd.idx[3:0]]);
        mb = 33'(v[mat_col(cmd.idx[3:0])]);
      end
      OP_SQ: begin
        ma = 33'(g[cmd.idx[1:0]]);
        mb = 33'(g[cmd.idx[1:0]]);
      end
      OP_AMUL: begin
        ma = {1'b0, sr_r[31:0]};
        mb = {9'd0, dt};
      end
      OP_AXMUL: begin
        ma = 33'(sv);
        mb = 33'(g[cmd.ax]);
      end
      OP_QMUL: begin
        ma = 33'(wq[cmd.idx[1:0]]);
        mb = 33'(q[qmul_q(cmd.idx[3:0])]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    gsum  = ((mat_col(cmd.idx[3:0]) == 2'd0) ? 40'sd0 : acc) + 40'(rnd);
    qterm = qmul_neg(cmd.idx[3:0]) ? -40'(rnd) : 40'(rnd);
    qsum  = ((cmd.idx[1:0] == 2'd0) ? 40'sd0 : acc) + qterm;
    xcur  = (cmd.idx == 5'd0) ? sq : sr_x;
    rcur  = (cmd.idx == 5'd0) ? 64'd0 : sr_r;
    sbit  = 64'd1 << (6'd62 - {cmd.idx, 1'b0});
    trial = rcur + sbit;
    mod_d = TWO_PI_U38 << (3'(AMOD_LAST) - cmd.idx[2:0]);
    a1    = {2'b00, am[32:0]};
    if (a1 > PI_Q30) begin
      a1 = a1 - TWO_PI_Q30;
    end
    at    = $signed({3'b000, atan_q30(cmd.idx)});
    xs    = cx >>> cmd.idx;
    ys    = cy >>> cmd.idx;
    mag   = mp[65] ? 64'(-mp) : 64'(mp);
    num   = mag + {33'd0, sr_r[31:1]};
    diff  = {1'b0, rem[31:0], nlo[31]} - {2'b00, sr_r[31:0]};
  end

  always_ff @(posedge clk) begin
    mp <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q[0]      <= ONE_Q30;
      q[1]      <= '0;
      q[2]      <= '0;
      q[3]      <= '0;
      init_q[0] <= ONE_Q30;
      init_q[1] <= '0;
      init_q[2] <= '0;
      init_q[3] <= '0;
      min_rate  <= MIN_RATE_RST;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_INIT_W:   init_q[0] <= cfg_data;
          REG_INIT_X:   init_q[1] <= cfg_data;
          REG_INIT_Y:   init_q[2] <= cfg_data;
          REG_INIT_Z:   init_q[3] <= cfg_data;
          REG_MIN_RATE: min_rate  <= cfg_data[23:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          if (restart) begin
            q <= init_q;
          end
        end
        OP_FINISH: begin
          if (!held_r) begin
            q <= nq;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        v[0] <= rate_x;
        v[1] <= rate_y;
        v[2] <= rate_z;
        dt   <= step_time;
      end
      OP_QPROD: begin
        if (cmd.ph) begin
          pr[cmd.idx[3:0]] <= rnd;
        end
      end
      OP_MBUILD: begin
        m[0] <= sat32(40'(pr[0]) + 40'(pr[1]) - 40'(pr[2]) - 40'(pr[3]));
        m[1] <= sat32((40'(pr[4]) - 40'(pr[9])) <<< 1);
        m[2] <= sat32((40'(pr[5]) + 40'(pr[8])) <<< 1);
        m[3] <= sat32((40'(pr[4]) + 40'(pr[9])) <<< 1);
        m[4] <= sat32(40'(pr[0]) - 40'(pr[1]) + 40'(pr[2]) - 40'(pr[3]));
        m[5] <= sat32((40'(pr[6]) - 40'(pr[7])) <<< 1);
        m[6] <= sat32((40'(pr[5]) - 40'(pr[8])) <<< 1);
        m[7] <= sat32((40'(pr[6]) + 40'(pr[7])) <<< 1);
        m[8] <= sat32(40'(pr[0]) - 40'(pr[1]) - 40'(pr[2]) + 40'(pr[3]));
      end
      OP_GMUL: begin
        if (cmd.ph) begin
          acc <= gsum;
          if (mat_col(cmd.idx[3:0]) == 2'd2) begin
            g[mat_row(cmd.idx[3:0])] <= sat32(gsum);
          end
        end
      end
      OP_SQ: begin
        if (cmd.ph) begin
          sq <= ((cmd.idx == 5'd0) ? 64'd0 : sq) + mp[63:0];
        end
      end
      OP_SQRT: begin
        if (xcur >= trial) begin
          sr_x <= xcur - trial;
          sr_r <= (rcur >> 1) + sbit;
        end else begin
          sr_x <= xcur;
          sr_r <= rcur >> 1;
        end
      end
      OP_CHECK: held_r <= status.slow;
      OP_AMUL: begin
        if (cmd.ph) begin
          am <= mp[56:19];
        end
      end
      OP_AMOD: begin
        if (am >= mod_d) begin
          am <= am - mod_d;
        end
      end
      OP_FOLD: begin
        cx <= CORDIC_K;
        cy <= '0;
        if (a1 > HALF_PI_Q30) begin
          ang  <= PI_Q30 - a1;
          flip <= 1'b1;
        end else if (a1 < -HALF_PI_Q30) begin
          ang  <= -PI_Q30 - a1;
          flip <= 1'b1;
        end else begin
          ang  <= a1;
          flip <= 1'b0;
        end
      end
      OP_CORDIC: begin
        if (!ang[34]) begin
          cx  <= cx - ys;
          cy  <= cy + xs;
          ang <= ang - at;
        end else begin
          cx  <= cx + ys;
          cy  <= cy - xs;
          ang <= ang + at;
        end
      end
      OP_CS: begin
        wq[0] <= flip ? 32'(-cx) : 32'(cx);
        sv    <= 32'(cy);
      end
      OP_AXMUL: begin
        if (cmd.ph) begin
          neg <= mp[65];
          rem <= {1'b0, num[63:32]};
          nlo <= num[31:0];
        end
      end
      OP_AXDIV: begin
        if (!diff[33]) begin
          rem <= diff[32:0];
        end else begin
          rem <= {rem[31:0], nlo[31]};
        end
        quo <= {quo[30:0], ~diff[33]};
        nlo <= nlo << 1;
      end
      OP_AXDONE: wq[2'(cmd.ax + 2'd1)] <= neg ? -quo : quo;
      OP_QMUL: begin
        if (cmd.ph) begin
          acc <= qsum;
          if (cmd.idx[1:0] == 2'd3) begin
            nq[cmd.idx[3:2]] <= sat32(qsum);
          end
        end
      end
      OP_FINISH: begin
        oq   <= held_r ? q : nq;
        held <= held_r;
      end
      default: ;
    endcase
  end

  assign quat_w = oq[0];
  assign quat_x = oq[1];
  assign quat_y = oq[2];
  assign quat_z = oq[3];

endmodule

// ===== hdl/gqi_checker.sv =====
// Port-level checker of the gyro quaternion integrator, bound to the top level.
// Depends on gyro_quaternion_integrator_defines.svh.
`timescale 1ns / 1ps
`include "gyro_quaternion_integrator_defines.svh"

module gqi_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  `GQI_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `GQI_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `GQI_ASSERT_NOW(a_result_then_idle, clk, rst, $rose(m_axis_tvalid), s_axis_tready)
  `GQI_ASSERT_ALWAYS(a_reset_state, clk, rst, !m_axis_tvalid && s_axis_tready)

endmodule

bind gyro_quaternion_integrator gqi_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/gyro_quaternion_integrator_tb.sv =====
// Self-checking testbench of gyro_quaternion_integrator: bursty stream stimulus,
// stalling receiver, bit-exact orientation predictor. Depends on gqi_pkg and the RTL.
`timescale 1ns / 1ps

module gyro_quaternion_integrator_tb;
  import gqi_pkg::*;

  localparam int STEPS = 24;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam longint ATAN [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
    8388437, 4194282, 2097149, 1048575, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
  localparam longint PI_L = 64'd3373259426;
  localparam longint TWO_PI_L = 64'd6746518852;
  localparam longint HALF_PI_L = 64'd1686629713;

  typedef struct {
    logic              restart;
    logic signed [31:0] rate_x, rate_y, rate_z;
    logic [23:0]       step_time;
  } rate_item_t;

  typedef struct {
    logic [31:0] quat_w, quat_x, quat_y, quat_z;
    logic        held;
  } quat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;  // rate_x, rate_y, rate_z, step_time
  logic         s_axis_tuser = 1'b0;  // restart
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;  // quat_w, quat_x, quat_y, quat_z
  logic         m_axis_tuser;  // held

  gyro_quaternion_integrator #(.CORDIC_STEPS(STEPS)) dut (.*);

  rate_item_t pending_items[$];
  quat_t      expected_quats[$];
  longint     orient[4];
  longint     init_q[4];
  longint     min_rate_m;
  int         errors = 0;
  int         idle_cycles = 0;
  bit         item_busy = 0;
  int         burst_left = 4;
  int         gap_left = 0;
  int         stall_mode = 0;
  int         stall_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint mul30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint axis_part(longint s, longint g, longint unsigned len);
    longint p;
    longint unsigned m, q;
    p = s * g;
    m = (p < 0) ? longint'(-p) : longint'(p);
    q = (m + len / 2) / len;
    return (p < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic quat_t integrate(rate_item_t it);
    longint v[3], g[3], mt[9], q[4], acc, a, x, y, xs, ys, c, s, sx, sy, sz;
    longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint unsigned sq, len;
    bit flip;
    quat_t r;
    if (it.restart) orient = init_q;
    v[0] = it.rate_x; v[1] = it.rate_y; v[2] = it.rate_z;
    q = orient;
    ww = mul30(q[0], q[0]); xx = mul30(q[1], q[1]);
    yy = mul30(q[2], q[2]); zz = mul30(q[3], q[3]);
    xy = mul30(q[1], q[2]); xz = mul30(q[1], q[3]); yz = mul30(q[2], q[3]);
    wx = mul30(q[0], q[1]); wy = mul30(q[0], q[2]); wz = mul30(q[0], q[3]);
    mt[0] = sat(ww + xx - yy - zz); mt[1] = sat(2 * (xy - wz)); mt[2] = sat(2 * (xz + wy));
    mt[3] = sat(2 * (xy + wz)); mt[4] = sat(ww - xx + yy - zz); mt[5] = sat(2 * (yz - wx));
    mt[6] = sat(2 * (xz - wy)); mt[7] = sat(2 * (yz + wx)); mt[8] = sat(ww - xx - yy + zz);
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += mul30(mt[3 * i + j], v[j]);
      g[i] = sat(acc);
      sq += longint'(g[i] * g[i]);
    end
    len = isqrt(sq);
    r.held = (len <= longint'(min_rate_m));
    if (!r.held) begin
      a = longint'(((len * longint'(it.step_time)) >> 19) % TWO_PI_L);
      x = CORDIC_K;
      y = 0;
      flip = 0;
      if (a > PI_L) a -= TWO_PI_L;
      if (a > HALF_PI_L) begin
        a = PI_L - a;
        flip = 1;
      end else if (a < -HALF_PI_L) begin
        a = -PI_L - a;
        flip = 1;
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (a >= 0) begin
          x -= ys; y += xs; a -= ATAN[i];
        end else begin
          x += ys; y -= xs; a += ATAN[i];
        end
      end
      c = flip ? -x : x;
      s = y;
      sx = axis_part(s, g[0], len);
      sy = axis_part(s, g[1], len);
      sz = axis_part(s, g[2], len);
      orient[0] = sat(mul30(c, q[0]) - mul30(sx, q[1]) - mul30(sy, q[2]) - mul30(sz, q[3]));
      orient[1] = sat(mul30(c, q[1]) + mul30(sx, q[0]) + mul30(sy, q[3]) - mul30(sz, q[2]));
      orient[2] = sat(mul30(c, q[2]) - mul30(sx, q[3]) + mul30(sy, q[0]) + mul30(sz, q[1]));
      orient[3] = sat(mul30(c, q[3]) + mul30(sx, q[2]) - mul30(sy, q[1]) + mul30(sz, q[0]));
    end
    r.quat_w = orient[0][31:0];
    r.quat_x = orient[1][31:0];
    r.quat_y = orient[2][31:0];
    r.quat_z = orient[3][31:0];
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    if (idx < REG_MIN_RATE) init_q[idx] = longint'(signed'(val));
    else if (idx == REG_MIN_RATE) min_rate_m = val[23:0];
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic add_item(logic rs, logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                          logic [23:0] st);
    rate_item_t it;
    it.restart = rs;
    it.rate_x = rx; it.rate_y = ry; it.rate_z = rz;
    it.step_time = st;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_rate();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
    if (k < 8) return {{14{1'b0}}, 18'($urandom)} - 32'h0002_0000;
    return $urandom;
  endfunction

  function automatic logic [23:0] rand_step();
    if ($urandom_range(0, 9) < 8) return 24'($urandom_range(0, 20000));
    return 24'($urandom);
  endfunction

  task automatic add_random(int n);
    for (int i = 0; i < n; i++)
      add_item($urandom_range(0, 19) == 0, rand_rate(), rand_rate(), rand_rate(),
               rand_step());
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !item_busy && expected_quats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    init_q = '{ONE_Q30, 0, 0, 0};
    orient = init_q;
    min_rate_m = MIN_RATE_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Defaults: held, extremes, large angles, restart.
    add_item(0, 0, 0, 0, 24'hFFFFFF);
    add_item(0, 32'd10, 0, 0, 24'd1000);
    add_item(0, 32'h0100_0000, 0, 0, 24'h01_0000);
    add_item(0, 0, 32'h0100_0000, 0, 24'h10_0000);
    add_item(0, 0, 0, 32'h0100_0000, 24'h80_0000);
    add_item(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF);
    add_item(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFFFFFF);
    add_item(0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 24'h00_0001);
    add_item(0, 32'hFF00_0000, 32'h0080_0000, 32'hFFC0_0000, 24'd0);
    add_item(1, 32'h0320_0000, 0, 0, 24'h40_0000);
    add_item(0, 32'h0C90_0000, 32'hF370_0000, 0, 24'h80_0000);
    add_item(1, 0, 0, 32'd17, 24'hFFFFFF);
    add_item(0, 0, 0, 32'd18, 24'hFFFFFF);
    add_random(450);
    drain();

    // Non-unit and saturating initial quaternion, highest threshold.
    write_reg(REG_INIT_W, 32'h7FFF_FFFF);
    write_reg(REG_INIT_X, 32'h8000_0000);
    write_reg(REG_INIT_Y, 32'h7FFF_FFFF);
    write_reg(REG_INIT_Z, 32'h8000_0000);
    write_reg(REG_MIN_RATE, 32'h00FF_FFFF);
    end_writes();
    add_item(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFFFFFF);
    add_item(1, 32'h0100_0000, 32'h0100_0000, 0, 24'h00_8000);
    add_item(0, 0, 0, 0, 0);
    add_random(450);
    drain();

    // Zero threshold, rotated unit start; indexes past the list ignored.
    write_reg(REG_INIT_W, 32'h2D41_3CCD);
    write_reg(REG_INIT_X, 32'h0000_0000);
    write_reg(REG_INIT_Y, 32'h2D41_3CCD);
    write_reg(REG_INIT_Z, 32'h0000_0000);
    write_reg(REG_MIN_RATE, 32'h0000_0000);
    write_reg(3'd5, $urandom);
    write_reg(3'd7, $urandom);
    end_writes();
    add_item(1, 0, 0, 0, 24'hFFFFFF);
    add_item(0, 32'd1, 0, 0, 24'hFFFFFF);
    add_random(450);
    drain();

    // Random settings.
    write_reg(REG_INIT_W, $urandom);
    write_reg(REG_INIT_X, $urandom);
    write_reg(REG_INIT_Y, $urandom);
    write_reg(REG_INIT_Z, $urandom);
    write_reg(REG_MIN_RATE, $urandom_range(0, 32'h4_0000));
    write_reg(3'd6, $urandom);
    end_writes();
    add_random(450);
    drain();

    if (errors == 0) begin
      $display("gyro_quaternion_integrator regression: pass");
    end else begin
      $display("gyro_quaternion_integrator regression: fail");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (!rst && !item_busy) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (pending_items.size() > 0) begin
        s_axis_tdata <= {pending_items[0].step_time, pending_items[0].rate_z,
                         pending_items[0].rate_y, pending_items[0].rate_x};
        s_axis_tuser <= pending_items[0].restart;
        s_axis_tvalid <= 1'b1;
        item_busy = 1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 2000);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 39) == 0);
    endcase
  end

  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_quats.push_back(integrate(pending_items.pop_front()));
        item_busy = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_quats.size() == 0) begin
          $error("unexpected result: quat_w %h", m_axis_tdata[31:0]);
          errors++;
        end else begin
          exp_q = expected_quats.pop_front();
          if (m_axis_tdata[31:0] !== exp_q.quat_w) begin
            $error("quat_w expected %h actual %h", exp_q.quat_w, m_axis_tdata[31:0]);
            errors++;
          end
          if (m_axis_tdata[63:32] !== exp_q.quat_x) begin
            $error("quat_x expected %h actual %h", exp_q.quat_x, m_axis_tdata[63:32]);
            errors++;
          end
          if (m_axis_tdata[95:64] !== exp_q.quat_y) begin
            $error("quat_y expected %h actual %h", exp_q.quat_y, m_axis_tdata[95:64]);
            errors++;
          end
          if (m_axis_tdata[127:96] !== exp_q.quat_z) begin
            $error("quat_z expected %h actual %h", exp_q.quat_z, m_axis_tdata[127:96]);
            errors++;
          end
          if (m_axis_tuser !== exp_q.held) begin
            $error("held expected %b actual %b", exp_q.held, m_axis_tuser);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("gyro_quaternion_integrator regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
